// File: rtl/eprm_pkg.sv
// Shared types, constants and a median helper function of the echo pulse ranger.
`default_nettype none

package eprm_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned WINDOW_DEPTH  = 3;
  localparam int unsigned DIST_W        = 16;
  localparam int unsigned DIV_W         = 8;
  localparam int unsigned SLOT_W        = 2;
  localparam logic [DIV_W-1:0] US_PER_CM_RESET = 8'd58;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TRIGGERED,
    MODE_READING
  } ranger_mode_e;

  typedef enum logic [2:0] {
    STS_TRIG_OK,
    STS_TRIG_BUSY,
    STS_PULSE_START,
    STS_MEAS_DONE,
    STS_EDGE_RESET
  } status_e;

  typedef enum logic {
    OP_TRIGGER,
    OP_EDGE
  } opcode_e;

  typedef struct packed {
    logic accept;
    logic div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } dp_sts_t;

  function automatic logic [DIST_W-1:0] median3(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b,
                                                input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/eprm_ctrl.sv
// Controller state machine that sequences item intake, division and result hand-off.
`default_nettype none

module eprm_ctrl
  import eprm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.div_needed ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            state_d      = sts_i.div_needed ? ST_DIV : ST_OUT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/eprm_datapath.sv
// Datapath with ranger mode, start time, serial divider, sample ring and result registers.
`default_nettype none

module eprm_datapath
  import eprm_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [DIV_W-1:0]   cfg_wdata_i,
  input  wire logic               opcode_i,
  input  wire logic               echo_level_i,
  input  wire logic [31:0]        event_time_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o,
  output logic [2:0]              status_o,
  output logic [DIST_W-1:0]       raw_distance_o,
  output logic [DIST_W-1:0]       median_distance_o,
  output logic                    distance_saturated_o
);

  localparam int unsigned CMP_W  = TIME_BITS + DIV_W;
  localparam int unsigned EXT_W  = TIME_BITS + 20;
  localparam int unsigned CNT_W  = 4;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIST_W - 1);

  logic [DIV_W-1:0]      us_per_cm_q;
  ranger_mode_e          mode_q, mode_d;
  logic [TIME_BITS-1:0]  start_q;
  logic [DIST_W-1:0]     ring_q [WINDOW_DEPTH];
  logic [SLOT_W-1:0]     slot_q, slot_next;

  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [DIST_W-1:0]     quo_q, quo_d;
  logic [DIST_W-1:0]     num_q;
  logic [CNT_W-1:0]      cnt_q;

  status_e               status_q, res_status;
  logic [DIST_W-1:0]     raw_q, res_raw;
  logic [DIST_W-1:0]     med_q, med_d;
  logic                  sat_q, res_sat;

  logic [TIME_BITS-1:0]  t_cur;
  logic [TIME_BITS-1:0]  width;
  logic [EXT_W-1:0]      width_ext;
  logic                  is_measure;
  logic                  early_sat;
  logic                  load_res;
  logic                  push_en;
  logic [DIST_W-1:0]     push_val;
  logic [DIV_W:0]        rem_sh;
  logic                  rem_ge;
  logic [DIST_W-1:0]     win [WINDOW_DEPTH];

  assign t_cur     = TIME_BITS'(event_time_i);
  assign width     = t_cur - start_q;
  assign width_ext = EXT_W'(width);
  assign slot_next = (slot_q >= SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  assign is_measure = (opcode_i == OP_EDGE) && !echo_level_i && (mode_q == MODE_READING);
  assign early_sat  = (us_per_cm_q == '0) ||
                      (CMP_W'(width >> 12) >= CMP_W'(us_per_cm_q));

  assign rem_sh = {rem_q, num_q[DIST_W-1]};
  assign rem_ge = rem_sh >= {1'b0, us_per_cm_q};
  assign rem_d  = rem_ge ? DIV_W'(rem_sh - {1'b0, us_per_cm_q}) : rem_sh[DIV_W-1:0];
  assign quo_d  = {quo_q[DIST_W-2:0], rem_ge};

  assign sts_o.div_needed = is_measure && !early_sat;
  assign sts_o.div_last   = (cnt_q == '0);

  always_comb begin
    mode_d     = mode_q;
    load_res   = 1'b0;
    push_en    = 1'b0;
    push_val   = '1;
    res_status = STS_EDGE_RESET;
    res_raw    = '0;
    res_sat    = 1'b0;
    if (cmd_i.accept) begin
      load_res = !sts_o.div_needed;
      if (opcode_i == OP_TRIGGER) begin
        if (mode_q == MODE_IDLE) begin
          mode_d     = MODE_TRIGGERED;
          res_status = STS_TRIG_OK;
        end else begin
          res_status = STS_TRIG_BUSY;
        end
      end else if (echo_level_i && (mode_q == MODE_TRIGGERED)) begin
        mode_d     = MODE_READING;
        res_status = STS_PULSE_START;
      end else if (is_measure) begin
        mode_d     = MODE_IDLE;
        res_status = STS_MEAS_DONE;
        if (early_sat) begin
          push_en = 1'b1;
          res_raw = '1;
          res_sat = 1'b1;
        end
      end else begin
        mode_d     = MODE_IDLE;
        res_status = STS_EDGE_RESET;
      end
    end else if (cmd_i.div_step && sts_o.div_last) begin
      load_res   = 1'b1;
      push_en    = 1'b1;
      push_val   = quo_d;
      res_status = STS_MEAS_DONE;
      res_raw    = quo_d;
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win[i] = (push_en && (slot_next == SLOT_W'(i))) ? push_val : ring_q[i];
    end
    med_d = median3(win[0], win[1], win[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      us_per_cm_q <= US_PER_CM_RESET;
      mode_q      <= MODE_IDLE;
      start_q     <= '0;
      slot_q      <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        us_per_cm_q <= cfg_wdata_i;
      end
      mode_q <= mode_d;
      if (cmd_i.accept && (mode_d == MODE_READING) && (mode_q == MODE_TRIGGERED)) begin
        start_q <= t_cur;
      end
      if (push_en) begin
        slot_q            <= slot_next;
        ring_q[slot_next] <= push_val;
      end
      if (cmd_i.accept) begin
        cnt_q <= CNT_LAST;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rem_q <= width_ext[19:12];
      num_q <= {width_ext[11:0], 4'b0000};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      num_q <= {num_q[DIST_W-2:0], 1'b0};
      quo_q <= quo_d;
    end
    if (load_res) begin
      status_q <= res_status;
      raw_q    <= res_raw;
      sat_q    <= res_sat;
      med_q    <= med_d;
    end
  end

  assign status_o             = status_q;
  assign raw_distance_o       = raw_q;
  assign median_distance_o    = med_q;
  assign distance_saturated_o = sat_q;

endmodule

`default_nettype wire

// File: rtl/echo_pulse_ranger_median3.sv
// Top level of the ultrasonic echo ranger with a three-sample median filter.
//
// Input items carry an opcode (trigger request or echo edge), the echo level
// after the edge and a microsecond timestamp; each is taken when in_valid_i
// and in_ready_o are both high. Every item yields exactly one result item on
// the output channel, taken when out_valid_o and out_ready_i are both high.
// The us_per_cm register is written through cfg_we_i and cfg_wdata_i.
// A trigger or a non-measuring edge has its result valid in the cycle after
// it is taken. A falling edge that ends a pulse runs a restoring divider
// that produces one quotient bit per cycle for a 16-bit quotient; an
// out-of-range pulse or a zero divisor saturates instead and has its result
// valid in the cycle after it is taken.
// One item is in work at a time. A new item is taken in the same cycle the
// pending result is taken, so an unstalled receiver sees one item every
// cycle for short items, while a measurement must first finish its division.
// While the receiver stalls, the result holds and no new item is taken.
// Reset returns the ranger to idle, clears the start time and the sample ring
// and loads us_per_cm with 58.
`default_nettype none

module echo_pulse_ranger_median3
  import eprm_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DIV_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              opcode_i,
  input  wire logic              echo_level_i,
  input  wire logic [31:0]       event_time_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             status_o,
  output logic [DIST_W-1:0]      raw_distance_o,
  output logic [DIST_W-1:0]      median_distance_o,
  output logic                   distance_saturated_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  eprm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eprm_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .opcode_i             (opcode_i),
    .echo_level_i         (echo_level_i),
    .event_time_i         (event_time_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .status_o             (status_o),
    .raw_distance_o       (raw_distance_o),
    .median_distance_o    (median_distance_o),
    .distance_saturated_o (distance_saturated_o)
  );

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the echo pulse ranger with its three-sample median filter.
`timescale 1ns / 1ps

module testbench
  import eprm_pkg::*;
();

  typedef struct {
    opcode_e     op;
    logic        level;
    logic [31:0] stamp;
    bit          drain_first;
  } echo_item_t;

  typedef struct {
    status_e     status;
    logic [15:0] raw;
    logic [15:0] median;
    logic        sat;
  } range_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  echo_item_t cur_item = '{OP_TRIGGER, 1'b0, 32'd0, 1'b0};

  logic in_ready;
  logic out_valid;
  logic [2:0] status;
  logic [15:0] raw_distance;
  logic [15:0] median_distance;
  logic distance_saturated;

  echo_item_t pending_items[$];
  range_result_t results_pending[$];

  ranger_mode_e mode_q = MODE_IDLE;
  logic [31:0] start_q = 32'd0;
  logic [15:0] ring_q [3] = '{16'd0, 16'd0, 16'd0};
  logic [1:0] slot_q = 2'd0;
  logic [7:0] divisor_q = US_PER_CM_RESET;

  int items_offered = 0;
  int items_accepted = 0;
  int fails = 0;
  int measured = 0;
  int saturated = 0;
  int send_gap = 0;
  int stall_left = 0;
  int long_stalls_asked = 0;
  int long_stalls_done = 0;
  bit gaps_on = 1'b1;
  bit drain_next = 1'b0;

  echo_pulse_ranger_median3 u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .opcode_i            (cur_item.op),
    .echo_level_i        (cur_item.level),
    .event_time_i        (cur_item.stamp),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .status_o            (status),
    .raw_distance_o      (raw_distance),
    .median_distance_o   (median_distance),
    .distance_saturated_o(distance_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] mid_of_three(input logic [15:0] a, input logic [15:0] b,
                                               input logic [15:0] c);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] capped;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    capped = (c < hi) ? c : hi;
    return (capped > lo) ? capped : lo;
  endfunction

  function automatic range_result_t step_ranger(input echo_item_t it);
    range_result_t res;
    logic [31:0] width;
    logic [63:0] quo;
    res = '{STS_TRIG_OK, 16'd0, 16'd0, 1'b0};
    if (it.op == OP_TRIGGER) begin
      if (mode_q == MODE_IDLE) begin
        mode_q = MODE_TRIGGERED;
        res.status = STS_TRIG_OK;
      end else begin
        res.status = STS_TRIG_BUSY;
      end
    end else if (it.level && mode_q == MODE_TRIGGERED) begin
      mode_q = MODE_READING;
      start_q = it.stamp;
      res.status = STS_PULSE_START;
    end else if (!it.level && mode_q == MODE_READING) begin
      mode_q = MODE_IDLE;
      width = it.stamp - start_q;
      quo = 64'hFFFF_FFFF_FFFF_FFFF;
      if (divisor_q != 8'd0) begin
        quo = {28'd0, width, 4'd0} / {56'd0, divisor_q};
      end
      if (quo > 64'd65535) begin
        res.raw = 16'hFFFF;
        res.sat = 1'b1;
      end else begin
        res.raw = quo[15:0];
      end
      slot_q = (slot_q >= 2'd2) ? 2'd0 : slot_q + 2'd1;
      ring_q[slot_q] = res.raw;
      res.status = STS_MEAS_DONE;
    end else begin
      mode_q = MODE_IDLE;
      res.status = STS_EDGE_RESET;
    end
    res.median = mid_of_three(ring_q[0], ring_q[1], ring_q[2]);
    return res;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && items_accepted < items_offered) begin
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (pending_items.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_items[0].drain_first && results_pending.size() != 0) begin
      in_valid <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      send_gap = $urandom_range(0, 14);
    end else begin
      cur_item <= pending_items.pop_front();
      in_valid <= 1'b1;
      items_offered++;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (long_stalls_done < long_stalls_asked) begin
      out_ready <= 1'b0;
      stall_left = 299;
      long_stalls_done++;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    range_result_t exp_res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_pending.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result: status %0d raw %0d median %0d sat %0b",
                     status, raw_distance, median_distance, distance_saturated);
          end
        end else begin
          exp_res = results_pending.pop_front();
          if (status !== exp_res.status || raw_distance !== exp_res.raw ||
              median_distance !== exp_res.median || distance_saturated !== exp_res.sat) begin
            fails++;
            if (fails <= 10) begin
              $display("status raw median sat: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                       exp_res.status, exp_res.raw, exp_res.median, exp_res.sat,
                       status, raw_distance, median_distance, distance_saturated);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        exp_res = step_ranger(cur_item);
        if (exp_res.status == STS_MEAS_DONE) measured++;
        if (exp_res.sat) saturated++;
        results_pending.push_back(exp_res);
        items_accepted++;
      end
    end
  end

  task automatic add_item(input opcode_e op, input logic level, input logic [31:0] stamp);
    echo_item_t it;
    it = '{op, level, stamp, drain_next};
    drain_next = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic queue_ranging(input int count, input logic [7:0] d);
    int unsigned span;
    logic [31:0] t0;
    logic [31:0] w;
    int made;
    span = 32'(d) << 12;
    made = 0;
    while (made < count) begin
      t0 = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4095) : $urandom;
      case ($urandom_range(0, 5))
        0: w = $urandom;
        1: w = span - 1 + $urandom_range(0, 1);
        2: w = $urandom_range(0, 255);
        default: w = $urandom_range(0, span + 4095);
      endcase
      case ($urandom_range(0, 9))
        7: begin
          add_item(OP_TRIGGER, 1'($urandom_range(0, 1)), $urandom);
          add_item(OP_EDGE, 1'b1, t0);
          if ($urandom_range(0, 1) == 0) begin
            add_item(OP_EDGE, 1'b1, t0 + w);
          end else begin
            add_item(OP_TRIGGER, 1'($urandom_range(0, 1)), $urandom);
          end
          add_item(OP_EDGE, 1'b0, t0 + w);
          made += 4;
        end
        8, 9: begin
          repeat ($urandom_range(1, 4)) begin
            add_item(opcode_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
            made++;
          end
          add_item(OP_EDGE, 1'b0, $urandom);
          made++;
        end
        default: begin
          add_item(OP_TRIGGER, 1'($urandom_range(0, 1)), $urandom);
          add_item(OP_EDGE, 1'b1, t0);
          add_item(OP_EDGE, 1'b0, t0 + w);
          made += 3;
        end
      endcase
    end
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || items_accepted != items_offered ||
           results_pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [7:0] d);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    divisor_q = d;
  endtask

  initial begin
    logic [7:0] mid_div;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Unexpected edges, busy triggers, wrapped and boundary pulse widths.
    add_item(OP_EDGE, 1'b0, 32'h0000_0000);
    add_item(OP_EDGE, 1'b1, 32'hFFFF_FFFF);
    add_item(OP_TRIGGER, 1'b0, 32'h0);
    add_item(OP_TRIGGER, 1'b1, 32'hFFFF_FFFF);
    add_item(OP_EDGE, 1'b0, 32'h1234_5678);
    add_item(OP_TRIGGER, 1'b0, 32'h0);
    add_item(OP_EDGE, 1'b1, 32'hFFFF_FFF0);
    add_item(OP_TRIGGER, 1'b0, 32'h0);
    add_item(OP_EDGE, 1'b0, 32'h0000_0100);
    add_item(OP_TRIGGER, 1'b0, 32'h0);
    add_item(OP_EDGE, 1'b1, 32'h0);
    add_item(OP_EDGE, 1'b0, 32'h0);
    add_item(OP_TRIGGER, 1'b0, 32'h0);
    add_item(OP_EDGE, 1'b1, 32'h0);
    add_item(OP_EDGE, 1'b0, 32'hFFFF_FFFF);
    add_item(OP_TRIGGER, 1'b0, 32'h0);
    add_item(OP_EDGE, 1'b1, 32'd1000);
    add_item(OP_EDGE, 1'b0, 32'd1000 + 32'd237567);
    add_item(OP_TRIGGER, 1'b0, 32'h0);
    add_item(OP_EDGE, 1'b1, 32'd1000);
    add_item(OP_EDGE, 1'b0, 32'd1000 + 32'd237568);
    add_item(OP_TRIGGER, 1'b0, 32'h0);
    add_item(OP_EDGE, 1'b1, 32'hAAAA_5555);
    add_item(OP_EDGE, 1'b1, 32'h5555_AAAA);
    queue_ranging(230, US_PER_CM_RESET);

    write_divisor(8'd1);
    queue_ranging(250, 8'd1);
    long_stalls_asked++;

    write_divisor(8'd255);
    queue_ranging(120, 8'd255);
    drain_next = 1'b1;
    queue_ranging(130, 8'd255);

    write_divisor(8'd0);
    queue_ranging(100, 8'd0);

    mid_div = 8'($urandom_range(2, 254));
    write_divisor(mid_div);
    queue_ranging(250, mid_div);

    settle();
    gaps_on = 1'b0;
    mid_div = 8'($urandom_range(1, 255));
    write_divisor(mid_div);
    queue_ranging(300, mid_div);
    settle();

    $display("Ran %0d items with %0d completed measurements, %0d of them clipped,",
             items_accepted, measured, saturated);
    $display("over divisor settings 58, 1, 255, 0 and two random ones.");
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

// File: files.f
rtl/eprm_pkg.sv
rtl/eprm_ctrl.sv
rtl/eprm_datapath.sv
rtl/echo_pulse_ranger_median3.sv
bench/testbench.sv
